/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define CSW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define CSW_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

/* sv/csw_pkg.sv */
// ----------------------------------------------------------------------------
// Semaphore engine package
// Request/response payload types and operation and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csw_pkg;

   localparam int unsigned CountW = 8;

   // operation codes
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_LOCK   = 2'd1;
   localparam logic [1:0] OP_UNLOCK = 2'd2;

   // result codes
   localparam logic [2:0] KIND_CREATED   = 3'd0;
   localparam logic [2:0] KIND_GRANTED   = 3'd1;
   localparam logic [2:0] KIND_SUSPENDED = 3'd2;
   localparam logic [2:0] KIND_RAISED    = 3'd3;
   localparam logic [2:0] KIND_WOKEN     = 3'd4;
   localparam logic [2:0] KIND_NO_ID     = 3'd5;
   localparam logic [2:0] KIND_FULL      = 3'd6;

   localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] sem_id;
      logic [4:0] caller_pid;
      logic [7:0] initial_count;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [3:0] created_id;
      logic [4:0] woken_pid;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/csw_sem_table.sv */
// ----------------------------------------------------------------------------
// Semaphore descriptor table
// One-read one-write synchronous RAM with per-entry valid bits; entries never
// written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_sem_table #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic      [DATA_W-1:0]        rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
   input  wire logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   // unwritten entry: reset value
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* sv/counting_semaphore_wait_queue.sv */
// ----------------------------------------------------------------------------
// Counting semaphore engine with per-semaphore FIFO wait queues
// Create / lock / unlock service for a small kernel, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with rsp_valid high. The
// receiver cannot stall: a result must be captured in its strobe cycle.
// Create writes a fresh descriptor; lock and an unlock that raises the count
// do a descriptor read, then modify/write-back. The result strobes in the
// cycle in which busy goes low again, and a new request may be started in
// that same cycle.
// An unlock that wakes a waiter adds ST_WAKE: the wait-queue slot address
// comes out of the descriptor read, so the wait-store read follows it in
// series. Reset is immediate; no clearing pass runs (the descriptor table has
// valid bits and the wait store is only read where a lock has written it).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module counting_semaphore_wait_queue #(
   parameter int SEM_COUNT  = 16,  // 2..16
   parameter int WAIT_DEPTH = 16   // 2..256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire csw_pkg::req_type req_data,
   output logic                  rsp_valid,
   output csw_pkg::rsp_type      rsp_data
);

   localparam int SemIdxW   = $clog2(SEM_COUNT);
   localparam int NfidW     = $clog2(SEM_COUNT + 1);
   localparam int SlotW     = $clog2(WAIT_DEPTH);
   localparam int LenW      = $clog2(WAIT_DEPTH + 1);
   localparam int WaitWords = SEM_COUNT * (2 ** SlotW);
   localparam int WaitAddrW = SemIdxW + SlotW;

   // per-semaphore descriptor: count plus ring pointers of the wait queue
   typedef struct packed {
      logic [csw_pkg::CountW-1:0] count;
      logic [SlotW-1:0]           head;
      logic [SlotW-1:0]           tail;
      logic [LenW-1:0]            len;
   } desc_type;

   localparam int DescW = $bits(desc_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAKE
   } state_type;

   state_type         state_ff, state_in;
   csw_pkg::req_type  req_ff;
   logic [NfidW-1:0]  nfid_ff, nfid_in;
   logic              rsp_valid_ff;
   csw_pkg::rsp_type  rsp_data_ff;

   logic              accept;
   logic              req_sid_ok;
   logic              hold_sid_ok;
   logic [SemIdxW-1:0] hold_idx;

   // descriptor table
   logic               tbl_rd_en;
   logic [DescW-1:0]   tbl_rd_data;
   desc_type           tbl_rd_desc;
   logic               tbl_wr_en;
   logic [SemIdxW-1:0] tbl_wr_idx;
   desc_type           tbl_wr_desc;

   // wait store: waiter pids, slot {sem, ring slot}
   logic [4:0]           wait_mem [WaitWords];
   logic [4:0]           wait_rd_ff;
   logic                 wait_wr_en;
   logic                 wait_rd_en;
   logic [WaitAddrW-1:0] wait_addr;

   logic [2:0]  kind_in;
   logic [3:0]  created_in;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign req_sid_ok  = int'(req_data.sem_id) < SEM_COUNT;
   assign hold_sid_ok = int'(req_ff.sem_id) < SEM_COUNT;
   assign hold_idx    = SemIdxW'(req_ff.sem_id);
   assign tbl_rd_desc = desc_type'(tbl_rd_data);

   // descriptor read is launched with the transfer itself
   assign tbl_rd_en = accept && req_sid_ok &&
                      ((req_data.op == csw_pkg::OP_LOCK) ||
                       (req_data.op == csw_pkg::OP_UNLOCK));

   csw_sem_table #(
      .DEPTH  (SEM_COUNT),
      .DATA_W (DescW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_idx  (SemIdxW'(req_data.sem_id)),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_idx  (tbl_wr_idx),
      .wr_data (tbl_wr_desc)
   );

   // ring pointer advance with wrap at WAIT_DEPTH
   function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
      logic [SlotW-1:0] r;
      if (s == SlotW'(WAIT_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   // read-modify-write of one descriptor in the EXEC cycle
   always_comb begin
      state_in    = state_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_idx  = hold_idx;
      tbl_wr_desc = tbl_rd_desc;
      wait_wr_en  = 1'b0;
      wait_rd_en  = 1'b0;
      wait_addr   = {hold_idx, tbl_rd_desc.tail};
      nfid_in     = nfid_ff;
      kind_in     = csw_pkg::KIND_NO_ID;
      created_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (req_ff.op)
               csw_pkg::OP_CREATE: begin
                  if (nfid_ff != NfidW'(SEM_COUNT)) begin
                     tbl_wr_en         = 1'b1;
                     tbl_wr_idx        = SemIdxW'(nfid_ff);
                     tbl_wr_desc.count = req_ff.initial_count;
                     tbl_wr_desc.head  = '0;
                     tbl_wr_desc.tail  = '0;
                     tbl_wr_desc.len   = '0;
                     nfid_in           = nfid_ff + 1'b1;
                     kind_in           = csw_pkg::KIND_CREATED;
                     created_in        = 4'(nfid_ff);
                  end
               end
               csw_pkg::OP_LOCK: begin
                  if (hold_sid_ok) begin
                     if (tbl_rd_desc.count != '0) begin
                        tbl_wr_en         = 1'b1;
                        tbl_wr_desc.count = tbl_rd_desc.count - 1'b1;
                        kind_in           = csw_pkg::KIND_GRANTED;
                     end else if (tbl_rd_desc.len == LenW'(WAIT_DEPTH)) begin
                        kind_in = csw_pkg::KIND_FULL;
                     end else begin
                        // append caller at tail
                        tbl_wr_en        = 1'b1;
                        tbl_wr_desc.tail = slot_next(tbl_rd_desc.tail);
                        tbl_wr_desc.len  = tbl_rd_desc.len + 1'b1;
                        wait_wr_en       = 1'b1;
                        wait_addr        = {hold_idx, tbl_rd_desc.tail};
                        kind_in          = csw_pkg::KIND_SUSPENDED;
                     end
                  end
               end
               csw_pkg::OP_UNLOCK: begin
                  if (hold_sid_ok) begin
                     if (tbl_rd_desc.len != '0) begin
                        // pop oldest waiter; pid comes out in ST_WAKE
                        tbl_wr_en        = 1'b1;
                        tbl_wr_desc.head = slot_next(tbl_rd_desc.head);
                        tbl_wr_desc.len  = tbl_rd_desc.len - 1'b1;
                        wait_rd_en       = 1'b1;
                        wait_addr        = {hold_idx, tbl_rd_desc.head};
                        state_in         = ST_WAKE;
                     end else begin
                        tbl_wr_en = 1'b1;
                        if (tbl_rd_desc.count != csw_pkg::COUNT_MAX) begin
                           tbl_wr_desc.count = tbl_rd_desc.count + 1'b1;
                        end
                        kind_in = csw_pkg::KIND_RAISED;
                     end
                  end
               end
               default: begin
                  kind_in = csw_pkg::KIND_NO_ID;
               end
            endcase
         end
         ST_WAKE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wait_wr_en) begin
         wait_mem[wait_addr] <= req_ff.caller_pid;
      end
      if (wait_rd_en) begin
         wait_rd_ff <= wait_mem[wait_addr];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // sequencer state, id allocator and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nfid_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         nfid_ff      <= nfid_in;
         rsp_valid_ff <= 1'b0;
         if ((state_ff == ST_EXEC) && (state_in == ST_IDLE)) begin
            rsp_valid_ff            <= 1'b1;
            rsp_data_ff.result_kind <= kind_in;
            rsp_data_ff.created_id  <= created_in;
            rsp_data_ff.woken_pid   <= '0;
         end else if (state_ff == ST_WAKE) begin
            rsp_valid_ff            <= 1'b1;
            rsp_data_ff.result_kind <= csw_pkg::KIND_WOKEN;
            rsp_data_ff.created_id  <= '0;
            rsp_data_ff.woken_pid   <= wait_rd_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----
   `CSW_ASSERT(a_rsp_single_cycle, rsp_valid |=> !rsp_valid, "result strobe held two cycles")
   `CSW_ASSERT(a_rsp_when_idle, rsp_valid |-> !busy, "result shown while still busy")
   `CSW_ASSERT(a_accept_goes_busy, accept |=> busy, "transfer did not start a request")
   `CSW_NEVER(a_push_full, wait_wr_en && (tbl_rd_desc.len == LenW'(WAIT_DEPTH)), "push when full")

endmodule

`default_nettype wire
